// File: design/kva_pkg.sv
// shared constants and control types for the keyboard voice allocator
// no dependencies; used by kva_ctrl, kva_datapath and keyboard_voice_allocator
`timescale 1ns / 1ps
`default_nettype none

package kva_pkg;

	localparam int NUM_SLOTS = 4;
	localparam int NUM_KEYS = 12;

	// width of the key level field on the input port
	localparam int KEY_FIELD_BITS = 12;
	// slots shown on the result port
	localparam int OUT_SLOTS = 4;
	localparam int OUT_KEY_W = 4;

	// slot key code: 0 empty, k+1 for key k
	localparam int KEY_W = $clog2(NUM_KEYS + 1);
	localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PUBLISH
	} kva_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic publish;
	} kva_cmd_t;

	typedef struct packed {
		logic last_key;
	} kva_sts_t;

endpackage

`default_nettype wire

// File: design/kva_datapath.sv
// voice slot registers, key counter and result registers of the allocator
// depends on kva_pkg; driven by kva_ctrl through kva_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module kva_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire kva_pkg::kva_cmd_t                   cmd,
	output kva_pkg::kva_sts_t                        sts,
	input  wire logic [kva_pkg::KEY_FIELD_BITS-1:0]  key_up_mask,
	input  wire logic                                octave_button,
	output logic [kva_pkg::OUT_SLOTS-1:0][kva_pkg::OUT_KEY_W-1:0] out_key,
	output logic [kva_pkg::OUT_SLOTS-1:0]            out_octave
);

	logic [kva_pkg::KEY_FIELD_BITS-1:0]              mask_q;
	logic                                            button_q;
	logic [kva_pkg::KIDX_W-1:0]                      kidx_q;
	logic [kva_pkg::NUM_SLOTS-1:0][kva_pkg::KEY_W-1:0] slot_key_q;
	logic [kva_pkg::NUM_SLOTS-1:0]                   slot_oct_q;
	logic [kva_pkg::NUM_SLOTS-1:0][kva_pkg::KEY_W-1:0] key_d;
	logic [kva_pkg::NUM_SLOTS-1:0]                   oct_d;
	logic [kva_pkg::KEY_W-1:0]                       code;
	logic                                            up;
	logic                                            hit;
	logic                                            found;

	assign sts.last_key = (kidx_q == kva_pkg::KIDX_W'(kva_pkg::NUM_KEYS - 1));
	assign code = kva_pkg::KEY_W'(kidx_q) + kva_pkg::KEY_W'(1);

	// keys past the input field read as released
	always_comb begin
		up = 1'b1;
		for (int k = 0; k < kva_pkg::KEY_FIELD_BITS; k++) begin
			if (kidx_q == kva_pkg::KIDX_W'(k)) begin
				up = mask_q[k];
			end
		end
	end

	// one key against all slots in parallel
	always_comb begin
		key_d = slot_key_q;
		oct_d = slot_oct_q;
		hit = 1'b0;
		found = 1'b0;
		for (int s = 0; s < kva_pkg::NUM_SLOTS; s++) begin
			if (slot_key_q[s] == code) begin
				hit = 1'b1;
			end
		end
		if (up) begin
			for (int s = 0; s < kva_pkg::NUM_SLOTS; s++) begin
				if (slot_key_q[s] == code) begin
					key_d[s] = '0;
					oct_d[s] = 1'b1;
				end
			end
		end else if (!hit) begin
			// lowest empty slot wins, no stealing when full
			for (int s = 0; s < kva_pkg::NUM_SLOTS; s++) begin
				if (!found && slot_key_q[s] == '0) begin
					key_d[s] = code;
					oct_d[s] = button_q;
					found = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_key_q <= '0;
			slot_oct_q <= '1;
			kidx_q <= '0;
		end else if (cmd.load) begin
			kidx_q <= '0;
		end else if (cmd.step) begin
			slot_key_q <= key_d;
			slot_oct_q <= oct_d;
			kidx_q <= sts.last_key ? '0 : kidx_q + kva_pkg::KIDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mask_q <= key_up_mask;
			button_q <= octave_button;
		end
	end

	// result registers, missing slots read as empty
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			for (int s = 0; s < kva_pkg::OUT_SLOTS; s++) begin
				if (s < kva_pkg::NUM_SLOTS) begin
					out_key[s] <= kva_pkg::OUT_KEY_W'(slot_key_q[s]);
					out_octave[s] <= slot_oct_q[s];
				end else begin
					out_key[s] <= '0;
					out_octave[s] <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: design/kva_ctrl.sv
// scan sequencer and result handshake of the allocator
// depends on kva_pkg; drives kva_datapath through kva_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module kva_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output kva_pkg::kva_cmd_t      cmd,
	input  wire kva_pkg::kva_sts_t sts
);

	kva_pkg::kva_state_t state_q;
	kva_pkg::kva_state_t state_d;
	logic                out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kva_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			kva_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = kva_pkg::ST_SCAN;
				end
			end
			kva_pkg::ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.last_key) begin
					state_d = kva_pkg::ST_PUBLISH;
				end
			end
			kva_pkg::ST_PUBLISH: begin
				// wait until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d = kva_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kva_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid)
		else $error("published result not shown");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken during a scan");

	a_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.load, cmd.step, cmd.publish}) <= 1)
		else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

// File: design/keyboard_voice_allocator.sv
// top level of the keyboard voice allocator: ports, sequencer and datapath
// depends on kva_pkg, kva_ctrl and kva_datapath
`timescale 1ns / 1ps
`default_nettype none

// Each request is one keyboard scan (12 key levels, 1 = released, plus the octave
// button). Keys are taken one per cycle, in order 0 to 11, against all four voice
// slots at once: a pressed key not yet held takes the lowest empty slot with the
// button level as its octave flag, a full set of slots drops it, and a released
// key empties every slot holding it. After the request is taken in the load cycle,
// the twelve keys pass in turn through the four parallel slot compares, and then
// the result register is filled. One scan is worked on at a time, and the next is
// taken as soon as the result is registered, even while it waits; a second
// finished scan stalls until the waiting result is taken.

module keyboard_voice_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [11:0] key_up_mask,
	input  wire logic        octave_button,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       slot0_key,
	output logic [3:0]       slot1_key,
	output logic [3:0]       slot2_key,
	output logic [3:0]       slot3_key,
	output logic             slot0_octave,
	output logic             slot1_octave,
	output logic             slot2_octave,
	output logic             slot3_octave
);

	kva_pkg::kva_cmd_t cmd;
	kva_pkg::kva_sts_t sts;
	logic [kva_pkg::OUT_SLOTS-1:0][kva_pkg::OUT_KEY_W-1:0] out_key;
	logic [kva_pkg::OUT_SLOTS-1:0] out_octave;

	kva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	kva_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.key_up_mask   (key_up_mask),
		.octave_button (octave_button),
		.out_key       (out_key),
		.out_octave    (out_octave)
	);

	assign slot0_key = out_key[0];
	assign slot1_key = out_key[1];
	assign slot2_key = out_key[2];
	assign slot3_key = out_key[3];
	assign slot0_octave = out_octave[0];
	assign slot1_octave = out_octave[1];
	assign slot2_octave = out_octave[2];
	assign slot3_octave = out_octave[3];

endmodule

`default_nettype wire
